// File: rtl/core/stopwatch_multiplexed_display_macros.svh
// assertion helpers for the stopwatch display block
`ifndef STOPWATCH_MULTIPLEXED_DISPLAY_MACROS_SVH
`define STOPWATCH_MULTIPLEXED_DISPLAY_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition that holds at every clock edge outside reset
`define SWMD_ASSERT_INV(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("swmd invariant violated");

// consequent must hold in the cycle after the antecedent
`define SWMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swmd next-cycle check violated");

`else

`define SWMD_ASSERT_INV(label, clk, rst, expr)
`define SWMD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/swmd_pkg.sv
`timescale 1ns / 1ps

package swmd_pkg;

   localparam int NUM_DIGITS_DEFAULT = 4;
   localparam int BCD_DIGITS         = 4;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 8;

   localparam logic [15:0] SHOWN_RESET     = 16'h8888;
   localparam logic [7:0]  THRESHOLD_RESET = 8'd10;
   localparam logic [7:0]  TPS_RESET       = 8'd5;
   localparam logic [7:0]  SPR_RESET       = 8'd10;
   localparam logic [7:0]  RPS_RESET       = 8'd10;
   localparam logic [1:0]  POINT_RESET     = 2'd2;

   localparam logic [5:0] SECONDS_WRAP = 6'd60;
   localparam logic [6:0] MINUTES_WRAP = 7'd100;

   // x / 10 == (x * 205) >> 11 for every 8-bit x
   localparam logic [15:0] DIV10_MUL   = 16'd205;
   localparam int          DIV10_SHIFT = 11;
   localparam logic [7:0]  RADIX       = 8'd10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE_THRESHOLD   = 3'd0,
      CSR_TICKS_PER_SAMPLE     = 3'd1,
      CSR_SAMPLES_PER_REFRESH  = 3'd2,
      CSR_REFRESHES_PER_SECOND = 3'd3,
      CSR_POINT_DIGIT          = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic start_level;
      logic stop_level;
   } req_type;

   typedef struct packed {
      logic [1:0] digit_index;
      logic [3:0] bcd_digit;
      logic       decimal_point;
      logic       running;
   } rsp_type;

   typedef struct packed {
      logic       stable;
      logic [7:0] count;
   } filt_type;

   function automatic logic [7:0] div10(input logic [7:0] v);
      logic [15:0] p;
      p = 16'(v) * DIV10_MUL;
      return 8'(p >> DIV10_SHIFT);
   endfunction

   function automatic logic [3:0] mod10(input logic [7:0] v);
      logic [7:0] q;
      logic [7:0] r;
      q = div10(v);
      r = v - 8'(q * RADIX);
      return r[3:0];
   endfunction

   // nibble k holds display digit k
   function automatic logic [15:0] bcd_split(input logic [15:0] value);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = value[7:0];
      hi = value[15:8];
      return {mod10(div10(hi)), mod10(hi), mod10(div10(lo)), mod10(lo)};
   endfunction

   function automatic filt_type debounce(input logic level, input logic stable,
                                         input logic [7:0] count,
                                         input logic [7:0] threshold);
      filt_type f;
      f.stable = stable;
      f.count  = '0;
      if (stable != level) begin
         f.count = count + 8'd1;
         if (f.count >= threshold) begin
            f.count  = '0;
            f.stable = level;
         end
      end
      return f;
   endfunction

endpackage

// File: rtl/core/stopwatch_multiplexed_display.sv
`timescale 1ns / 1ps
`include "stopwatch_multiplexed_display_macros.svh"
// stopwatch with debounced start/stop buttons and a multiplexed bcd display
//
// req channel: one request per display tick, carrying the raw start and
//    stop button levels (valid/ready)
// rsp channel: one result per request: enabled digit, its bcd value, the
//    decimal point and the run flag (valid/ready)
// csr port: plain write port, csr_we with csr_index and csr_wdata; the user writes it
//    only while the block is idle (the block does not enforce this); indexes beyond the list are ignored
// latency: a result is valid the cycle after its request is accepted
// throughput: one request per cycle while rsp_ready is high; all tick work (selector, prescalers,
//    debounce, bcd split, time count) is one registered pass from the
//    accepted request to the result register
// stall: the result register holds while rsp_ready is low; a new request is
//    taken in the same cycle the waiting result leaves, so no bubble
// reset: synchronous, active high; registers return to defaults, the digit
//    store clears and the display shows the start-up pattern until either
//    button matches its debounced level
module stopwatch_multiplexed_display #(
   parameter int NUM_DIGITS = swmd_pkg::NUM_DIGITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  swmd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output swmd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [swmd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [swmd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import swmd_pkg::*;

   localparam int SEL_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int IDX_W = (SEL_W > 2) ? SEL_W : 2;
   // only the four bcd digits exist; extra positions stay zero
   localparam int WRITE_DIGITS = (NUM_DIGITS < BCD_DIGITS) ? NUM_DIGITS : BCD_DIGITS;

   // configuration
   logic [7:0] threshold_ff;
   logic [7:0] ticks_per_sample_ff;
   logic [7:0] samples_per_refresh_ff;
   logic [7:0] refreshes_per_second_ff;
   logic [1:0] point_digit_ff;

   // prescaler chain
   logic [7:0] tick_phase_ff,    tick_phase_in;
   logic [7:0] sample_phase_ff,  sample_phase_in;
   logic [7:0] refresh_phase_ff, refresh_phase_in;
   logic       second_pending_ff, second_pending_in;

   // display
   logic [SEL_W-1:0] digit_select_ff, digit_select_in;
   logic [3:0]       digit_store_ff [NUM_DIGITS];
   logic [3:0]       digit_store_in [NUM_DIGITS];

   // buttons
   logic       start_stable_ff, start_stable_in;
   logic       start_seen_ff,   start_seen_in;
   logic [7:0] start_count_ff,  start_count_in;
   logic       stop_stable_ff,  stop_stable_in;
   logic       stop_seen_ff,    stop_seen_in;
   logic [7:0] stop_count_ff,   stop_count_in;

   // run control and time
   logic        run_toggle_ff,    run_toggle_in;
   logic        clear_toggle_ff,  clear_toggle_in;
   logic        timing_active_ff, timing_active_in;
   logic [5:0]  seconds_ff,       seconds_in;
   logic [6:0]  minutes_ff,       minutes_in;
   logic [15:0] shown_value_ff,   shown_value_in;
   logic        startup_done_ff,  startup_done_in;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic             req_accept;
   logic [SEL_W-1:0] sel_next;
   logic [IDX_W-1:0] sel_wide;
   logic [15:0]      bcd_parts;
   filt_type         start_filt;
   filt_type         stop_filt;

   // a new request may enter whenever the result slot is empty or draining
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // selector steps modulo the digit count
   assign sel_next = (digit_select_ff == SEL_W'(NUM_DIGITS - 1)) ? '0
                                                                 : digit_select_ff + 1'b1;
   assign sel_wide  = IDX_W'(sel_next);
   // bcd digits of the value held before this tick's updates
   assign bcd_parts = bcd_split(shown_value_ff);

   assign start_filt = debounce(req_data.start_level, start_stable_ff, start_count_ff,
                                threshold_ff);
   assign stop_filt  = debounce(req_data.stop_level, stop_stable_ff, stop_count_ff,
                                threshold_ff);

   always_comb begin
      tick_phase_in     = tick_phase_ff;
      sample_phase_in   = sample_phase_ff;
      refresh_phase_in  = refresh_phase_ff;
      second_pending_in = second_pending_ff;
      digit_select_in   = digit_select_ff;
      digit_store_in    = digit_store_ff;
      start_stable_in   = start_stable_ff;
      start_seen_in     = start_seen_ff;
      start_count_in    = start_count_ff;
      stop_stable_in    = stop_stable_ff;
      stop_seen_in      = stop_seen_ff;
      stop_count_in     = stop_count_ff;
      run_toggle_in     = run_toggle_ff;
      clear_toggle_in   = clear_toggle_ff;
      timing_active_in  = timing_active_ff;
      seconds_in        = seconds_ff;
      minutes_in        = minutes_ff;
      shown_value_in    = shown_value_ff;
      startup_done_in   = startup_done_ff;

      if (req_accept) begin
         digit_select_in = sel_next;

         // tick -> debounce sample -> digit refresh -> second
         tick_phase_in = tick_phase_ff + 8'd1;
         if (tick_phase_in >= ticks_per_sample_ff) begin
            tick_phase_in   = '0;
            start_stable_in = start_filt.stable;
            start_count_in  = start_filt.count;
            stop_stable_in  = stop_filt.stable;
            stop_count_in   = stop_filt.count;
            sample_phase_in = sample_phase_ff + 8'd1;
            if (sample_phase_in >= samples_per_refresh_ff) begin
               sample_phase_in = '0;
               for (int k = 0; k < WRITE_DIGITS; k++) begin
                  digit_store_in[k] = bcd_parts[4*k +: 4];
               end
               refresh_phase_in = refresh_phase_ff + 8'd1;
               if (refresh_phase_in >= refreshes_per_second_ff) begin
                  refresh_phase_in  = '0;
                  second_pending_in = 1'b1;
               end
            end
         end

         if (!startup_done_ff) begin
            // start-up pattern until a button agrees with its filtered level
            shown_value_in = SHOWN_RESET;
            if (req_data.start_level == start_stable_in) begin
               startup_done_in = 1'b1;
               run_toggle_in   = 1'b0;
               start_seen_in   = start_stable_in;
            end
            if (req_data.stop_level == stop_stable_in) begin
               startup_done_in = 1'b1;
               clear_toggle_in = 1'b0;
               stop_seen_in    = stop_stable_in;
            end
         end else begin
            // any debounced edge flips the matching flag
            if (start_stable_in != start_seen_ff) begin
               start_seen_in = start_stable_in;
               run_toggle_in = !run_toggle_ff;
            end
            if (stop_stable_in != stop_seen_ff) begin
               stop_seen_in    = stop_stable_in;
               clear_toggle_in = !clear_toggle_ff;
            end
            if (run_toggle_in) begin
               // fresh start realigns the prescalers, drops a pending second
               if (!timing_active_ff) begin
                  tick_phase_in     = '0;
                  sample_phase_in   = '0;
                  refresh_phase_in  = '0;
                  second_pending_in = 1'b0;
                  timing_active_in  = 1'b1;
               end
               if (second_pending_in) begin
                  second_pending_in = 1'b0;
                  seconds_in = seconds_ff + 6'd1;
                  if (seconds_in >= SECONDS_WRAP) begin
                     seconds_in = '0;
                     minutes_in = minutes_ff + 7'd1;
                     if (minutes_in >= MINUTES_WRAP) begin
                        minutes_in = '0;
                     end
                  end
                  // minutes in the high byte, seconds in the low byte
                  shown_value_in = {1'b0, minutes_in, 2'b00, seconds_in};
               end
            end else begin
               timing_active_in = 1'b0;
            end
            if (clear_toggle_in) begin
               shown_value_in   = '0;
               minutes_in       = '0;
               seconds_in       = '0;
               timing_active_in = 1'b0;
            end
         end
      end
   end

   // result fields: digit read before this tick's refresh
   always_comb begin
      rsp_data_in.digit_index   = sel_wide[1:0];
      rsp_data_in.bcd_digit     = digit_store_ff[sel_next];
      rsp_data_in.decimal_point = (sel_wide == IDX_W'(point_digit_ff));
      rsp_data_in.running       = run_toggle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff            <= THRESHOLD_RESET;
         ticks_per_sample_ff     <= TPS_RESET;
         samples_per_refresh_ff  <= SPR_RESET;
         refreshes_per_second_ff <= RPS_RESET;
         point_digit_ff          <= POINT_RESET;
         tick_phase_ff           <= '0;
         sample_phase_ff         <= '0;
         refresh_phase_ff        <= '0;
         second_pending_ff       <= 1'b0;
         digit_select_ff         <= '0;
         digit_store_ff          <= '{default: '0};
         start_stable_ff         <= 1'b0;
         start_seen_ff           <= 1'b0;
         start_count_ff          <= '0;
         stop_stable_ff          <= 1'b0;
         stop_seen_ff            <= 1'b0;
         stop_count_ff           <= '0;
         run_toggle_ff           <= 1'b0;
         clear_toggle_ff         <= 1'b0;
         timing_active_ff        <= 1'b0;
         seconds_ff              <= '0;
         minutes_ff              <= '0;
         shown_value_ff          <= SHOWN_RESET;
         startup_done_ff         <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_DEBOUNCE_THRESHOLD:   threshold_ff            <= csr_wdata;
               CSR_TICKS_PER_SAMPLE:     ticks_per_sample_ff     <= csr_wdata;
               CSR_SAMPLES_PER_REFRESH:  samples_per_refresh_ff  <= csr_wdata;
               CSR_REFRESHES_PER_SECOND: refreshes_per_second_ff <= csr_wdata;
               CSR_POINT_DIGIT:          point_digit_ff          <= csr_wdata[1:0];
               default: ;
            endcase
         end
         tick_phase_ff     <= tick_phase_in;
         sample_phase_ff   <= sample_phase_in;
         refresh_phase_ff  <= refresh_phase_in;
         second_pending_ff <= second_pending_in;
         digit_select_ff   <= digit_select_in;
         digit_store_ff    <= digit_store_in;
         start_stable_ff   <= start_stable_in;
         start_seen_ff     <= start_seen_in;
         start_count_ff    <= start_count_in;
         stop_stable_ff    <= stop_stable_in;
         stop_seen_ff      <= stop_seen_in;
         stop_count_ff     <= stop_count_in;
         run_toggle_ff     <= run_toggle_in;
         clear_toggle_ff   <= clear_toggle_in;
         timing_active_ff  <= timing_active_in;
         seconds_ff        <= seconds_in;
         minutes_ff        <= minutes_in;
         shown_value_ff    <= shown_value_in;
         startup_done_ff   <= startup_done_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // every accepted request leaves a result in the slot
   `SWMD_ASSERT_NEXT(a_accept_fills_slot, clock, reset, req_accept, rsp_valid_ff)
   // start-up pattern stays up until start-up completes
   `SWMD_ASSERT_INV(a_startup_pattern, clock, reset, startup_done_ff || (shown_value_ff == SHOWN_RESET))
   // a held clear never leaves timing running
   `SWMD_ASSERT_INV(a_clear_stops_timing, clock, reset, !clear_toggle_ff || !timing_active_ff)
   // time fields stay in their decimal range
   `SWMD_ASSERT_INV(a_time_range, clock, reset, (seconds_ff < SECONDS_WRAP) && (minutes_ff < MINUTES_WRAP))

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import swmd_pkg::*;

   localparam int NUM_DIGITS       = NUM_DIGITS_DEFAULT;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 4;
   localparam int PRINT_LIMIT      = 30;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   // debounced level plus its run of differing samples
   typedef struct packed {
      logic       stable;
      logic [7:0] count;
   } filter_state_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   stopwatch_multiplexed_display u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // stopwatch predictor: register copies and internal state
   // ------------------------------------------------------------------
   logic [7:0] cfg_threshold        = THRESHOLD_RESET;
   logic [7:0] cfg_sample_ticks     = TPS_RESET;
   logic [7:0] cfg_refresh_samples  = SPR_RESET;
   logic [7:0] cfg_second_refreshes = RPS_RESET;
   logic [1:0] cfg_point            = POINT_RESET;

   logic [7:0]       tick_div      = '0;
   logic [7:0]       sample_div    = '0;
   logic [7:0]       refresh_div   = '0;
   logic             second_due    = 1'b0;
   logic [1:0]       digit_ptr     = '0;
   logic [3:0]       digit_mem [NUM_DIGITS];
   filter_state_type start_filt    = '0;
   filter_state_type stop_filt     = '0;
   logic             start_ack     = 1'b0;
   logic             stop_ack      = 1'b0;
   logic             run_flag      = 1'b0;
   logic             clear_flag    = 1'b0;
   logic             counting      = 1'b0;
   logic [5:0]       secs          = '0;
   logic [6:0]       mins          = '0;
   logic [15:0]      display_value = SHOWN_RESET;
   logic             booted        = 1'b0;

   req_type pending_ticks[$];     // requests waiting for the driver
   rsp_type expected_display[$];  // predicted results, oldest first

   int  mismatches   = 0;
   int  cycle_count  = 0;
   logic req_fire    = 1'b0;      // request accepted at the last rising edge
   int  burst_left   = 0;
   int  gap_left     = 0;
   int  holds_asked  = 0;
   int  holds_served = 0;
   int  hold_left    = 0;
   int  mode_left    = 0;
   int  stall_step   = 0;
   stall_mode_type stall_mode = STALL_NONE;

   function automatic filter_state_type filter_level(input logic level,
                                                     input filter_state_type cur);
      filter_state_type nxt;
      nxt.stable = cur.stable;
      nxt.count  = 8'd0;
      if (level != cur.stable) begin
         nxt.count = cur.count + 8'd1;
         // threshold of zero accepts the new level at once
         if (nxt.count >= cfg_threshold) begin
            nxt.count  = 8'd0;
            nxt.stable = level;
         end
      end
      return nxt;
   endfunction

   // one display tick: advances the predictor and returns the result it shows
   task automatic advance_display(input req_type tick, output rsp_type shown);
      int lo;
      int hi;
      int k;
      logic [3:0] parts [4];
      // multiplex first: the digit shown is the one stored before any refresh
      digit_ptr = 2'((int'(digit_ptr) + 1) % NUM_DIGITS);
      shown.digit_index   = digit_ptr;
      shown.bcd_digit     = digit_mem[digit_ptr];
      shown.decimal_point = (digit_ptr == cfg_point);

      // prescale chain, each stage compared with >= so a lowered register fires at once
      tick_div = tick_div + 8'd1;
      if (tick_div >= cfg_sample_ticks) begin
         tick_div   = '0;
         start_filt = filter_level(tick.start_level, start_filt);
         stop_filt  = filter_level(tick.stop_level, stop_filt);
         sample_div = sample_div + 8'd1;
         if (sample_div >= cfg_refresh_samples) begin
            sample_div = '0;
            // minutes in the high byte, seconds in the low byte, two digits each
            lo = int'(display_value[7:0]);
            hi = int'(display_value[15:8]);
            parts[0] = 4'(lo % 10);
            parts[1] = 4'((lo / 10) % 10);
            parts[2] = 4'(hi % 10);
            parts[3] = 4'((hi / 10) % 10);
            for (k = 0; k < 4 && k < NUM_DIGITS; k++) digit_mem[k] = parts[k];
            refresh_div = refresh_div + 8'd1;
            if (refresh_div >= cfg_second_refreshes) begin
               refresh_div = '0;
               second_due  = 1'b1;
            end
         end
      end

      if (!booted) begin
         // start-up pattern until either raw level agrees with its debounced level
         display_value = SHOWN_RESET;
         if (tick.start_level == start_filt.stable) begin
            booted    = 1'b1;
            run_flag  = 1'b0;
            start_ack = start_filt.stable;
         end
         if (tick.stop_level == stop_filt.stable) begin
            booted     = 1'b1;
            clear_flag = 1'b0;
            stop_ack   = stop_filt.stable;
         end
      end else begin
         // any debounced edge, press or release, flips the matching flag
         if (start_filt.stable != start_ack) begin
            start_ack = start_filt.stable;
            run_flag  = !run_flag;
         end
         if (stop_filt.stable != stop_ack) begin
            stop_ack   = stop_filt.stable;
            clear_flag = !clear_flag;
         end
         if (run_flag) begin
            // run just started: restart the prescalers from zero
            if (!counting) begin
               tick_div    = '0;
               sample_div  = '0;
               refresh_div = '0;
               second_due  = 1'b0;
               counting    = 1'b1;
            end
            if (second_due) begin
               second_due = 1'b0;
               secs = secs + 6'd1;
               if (secs >= SECONDS_WRAP) begin
                  secs = '0;
                  mins = mins + 7'd1;
                  if (mins >= MINUTES_WRAP) mins = '0;
               end
               display_value = {1'b0, mins, 2'b00, secs};
            end
         end else begin
            counting = 1'b0;
         end
         // clear held: time stays zero and run keeps restarting the prescalers
         if (clear_flag) begin
            display_value = '0;
            mins          = '0;
            secs          = '0;
            counting      = 1'b0;
         end
      end
      shown.running = run_flag;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch %s: got %0d expected %0d at cycle %0d",
                  what, got, want, cycle_count);
   endtask

   // ------------------------------------------------------------------
   // monitor: predicts on each accepted request, checks each accepted result
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      rsp_type want_rsp;
      rsp_type next_rsp;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         // check before predicting so a result never meets its own request
         if (rsp_valid && rsp_ready) begin
            if (expected_display.size() == 0) begin
               report_mismatch("result with none expected", int'(rsp_data), 0);
            end else begin
               want_rsp = expected_display.pop_front();
               if (rsp_data.digit_index !== want_rsp.digit_index)
                  report_mismatch("digit_index", int'(rsp_data.digit_index),
                                  int'(want_rsp.digit_index));
               if (rsp_data.bcd_digit !== want_rsp.bcd_digit)
                  report_mismatch("bcd_digit", int'(rsp_data.bcd_digit),
                                  int'(want_rsp.bcd_digit));
               if (rsp_data.decimal_point !== want_rsp.decimal_point)
                  report_mismatch("decimal_point", int'(rsp_data.decimal_point),
                                  int'(want_rsp.decimal_point));
               if (rsp_data.running !== want_rsp.running)
                  report_mismatch("running", int'(rsp_data.running),
                                  int'(want_rsp.running));
            end
         end
         if (req_valid && req_ready) begin
            advance_display(req_data, next_rsp);
            expected_display.push_back(next_rsp);
         end
      end
   end

   // ------------------------------------------------------------------
   // driver: bursts of requests with random gaps, some bursts back to back
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (burst_left == 0 && gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (pending_ticks.size() != 0) begin
               req_data  <= pending_ticks.pop_front();
               req_valid <= 1'b1;
               burst_left--;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: changing stall modes, plus long hold-offs on request
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (holds_served != holds_asked) begin
            hold_left    = LONG_HOLD_CYCLES;
            holds_served = holds_asked;
         end
         if (hold_left > 0) begin
            // long stretch: block fills and backs up the request side
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            stall_step++;
            case (stall_mode)
               STALL_NONE:     rsp_ready <= 1'b1;
               STALL_LIGHT:    rsp_ready <= ($urandom_range(0, 3) != 0);
               STALL_PERIODIC: rsp_ready <= (stall_step % 3 != 0);
               default:        rsp_ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_hold(input logic start_lvl, input logic stop_lvl, input int n);
      req_type t;
      int i;
      t.start_level = start_lvl;
      t.stop_level  = stop_lvl;
      for (i = 0; i < n; i++) pending_ticks.push_back(t);
   endtask

   // sender pauses until every request is in and every result is out
   task automatic wait_idle();
      while (pending_ticks.size() != 0 || req_valid || expected_display.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DEBOUNCE_THRESHOLD:   cfg_threshold        = value;
         CSR_TICKS_PER_SAMPLE:     cfg_sample_ticks     = value;
         CSR_SAMPLES_PER_REFRESH:  cfg_refresh_samples  = value;
         CSR_REFRESHES_PER_SECOND: cfg_second_refreshes = value;
         CSR_POINT_DIGIT:          cfg_point            = value[1:0];
         default: ;
      endcase
   endtask

   task automatic set_rates(input logic [7:0] threshold, input logic [7:0] sample_ticks,
                            input logic [7:0] refresh_samples,
                            input logic [7:0] second_refreshes, input logic [1:0] point);
      write_reg(CSR_DEBOUNCE_THRESHOLD, threshold);
      write_reg(CSR_TICKS_PER_SAMPLE, sample_ticks);
      write_reg(CSR_SAMPLES_PER_REFRESH, refresh_samples);
      write_reg(CSR_REFRESHES_PER_SECOND, second_refreshes);
      write_reg(CSR_POINT_DIGIT, {6'd0, point});
   endtask

   // ticks needed to debounce a new level, capped for the slow settings
   function automatic int press_span();
      int s;
      s = int'(cfg_threshold) * int'(cfg_sample_ticks);
      if (s > 300) s = 300;
      return s;
   endfunction

   // drive buttons until the run and clear flags read as wanted
   task automatic settle_flags(input logic want_run, input logic want_clear);
      int tries;
      int span;
      span = press_span() + int'(cfg_sample_ticks) + 2;
      for (tries = 0; tries < 8; tries++) begin
         if (booted && run_flag == want_run && clear_flag == want_clear) break;
         if (!booted) begin
            push_hold(start_filt.stable, stop_filt.stable, 1);
         end else begin
            push_hold((run_flag != want_run) ? !start_filt.stable : start_filt.stable,
                      (clear_flag != want_clear) ? !stop_filt.stable : stop_filt.stable,
                      span);
         end
         wait_idle();
      end
   endtask

   // mostly well-formed presses and releases, some glitches and plain holds
   task automatic random_phase(input int count);
      int pushed;
      int pick;
      int len;
      int span;
      int i;
      logic cur_start;
      logic cur_stop;
      pushed    = 0;
      span      = press_span();
      cur_start = start_filt.stable;
      cur_stop  = stop_filt.stable;
      while (pushed < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            if ($urandom_range(0, 3) == 0) cur_stop = !cur_stop;
            else cur_start = !cur_start;
            len = span + $urandom_range(0, 3 * int'(cfg_sample_ticks) + 2);
            if (len < 1) len = 1;
            if (len > count - pushed) len = count - pushed;
            push_hold(cur_start, cur_stop, len);
         end else if (pick < 85) begin
            // glitch shorter than a full debounce
            len = $urandom_range(1, (span > 2) ? span - 1 : 1);
            if (len > count - pushed) len = count - pushed;
            for (i = 0; i < len; i++)
               push_hold(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
         end else begin
            len = $urandom_range(1, 20);
            if (len > count - pushed) len = count - pushed;
            push_hold(cur_start, cur_stop, len);
         end
         pushed += len;
      end
      wait_idle();
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int k;
      for (k = 0; k < NUM_DIGITS; k++) digit_mem[k] = 4'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: start-up held by raw levels away from the debounced ones,
      // then run on, a glitch, clear on while running, clear off, run off
      set_rates(8'd2, 8'd1, 8'd1, 8'd2, 2'd3);
      push_hold(1'b1, 1'b1, 3);
      push_hold(1'b0, 1'b1, 6);
      push_hold(1'b1, 1'b1, 1);
      push_hold(1'b0, 1'b1, 3);
      push_hold(1'b0, 1'b0, 3);
      push_hold(1'b0, 1'b1, 3);
      push_hold(1'b1, 1'b1, 3);
      wait_idle();

      // one second per tick, long enough for seconds to wrap into minutes;
      // the receiver holds off at the start so the block backs up
      set_rates(8'd1, 8'd1, 8'd1, 8'd1, 2'd0);
      settle_flags(1'b1, 1'b0);
      holds_asked++;
      push_hold(start_filt.stable, stop_filt.stable, 130);
      wait_idle();

      // clear held while running
      settle_flags(1'b1, 1'b1);
      push_hold(start_filt.stable, stop_filt.stable, 30);
      wait_idle();
      settle_flags(1'b0, 1'b0);

      // random phases across several settings, extremes among them
      set_rates(THRESHOLD_RESET, TPS_RESET, SPR_RESET, RPS_RESET, POINT_RESET);
      random_phase(200);
      set_rates(8'd255, 8'd255, 8'd255, 8'd255, 2'd3);
      random_phase(80);
      set_rates(8'd0, 8'd0, 8'd0, 8'd0, 2'd1);
      random_phase(150);
      set_rates(8'd255, 8'd1, 8'd1, 8'd1, 2'd0);
      random_phase(400);
      for (k = 0; k < 4; k++) begin
         set_rates(8'($urandom_range(1, 4)), 8'($urandom_range(1, 3)),
                   8'($urandom_range(1, 3)), 8'($urandom_range(1, 4)),
                   2'($urandom_range(0, 3)));
         random_phase(130);
      end

      wait_idle();
      if (mismatches == 0 && expected_display.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: stopwatch_multiplexed_display.f
+incdir+rtl/core
rtl/core/swmd_pkg.sv
rtl/core/stopwatch_multiplexed_display.sv
bench/testbench.sv
